// File: rtl/dual_quadrature_decoder_unit_defines.svh
// Assertion macros for the dual quadrature decoder RTL.
`ifndef DUAL_QUADRATURE_DECODER_UNIT_DEFINES_SVH
`define DUAL_QUADRATURE_DECODER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define DQD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define DQD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// File: rtl/dqd_pkg.sv
// Types and constants of the dual quadrature decoder.
package dqd_pkg;

  // Input item operation codes.
  typedef enum logic [0:0] {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_e;

  // Counting mode.
  typedef enum logic [0:0] {
    MODE_X2 = 1'b0,
    MODE_X4 = 1'b1
  } mode_e;

  // Count step chosen by one wheel decoder.
  typedef enum logic [1:0] {
    STEP_HOLD = 2'b00,
    STEP_INC  = 2'b01,
    STEP_DEC  = 2'b10
  } step_e;

  // Register indexes on the configuration port.
  localparam logic [0:0] REG_ENCODING_MODE = 1'b0;

  // Decoder verdict for one wheel.
  typedef struct packed {
    logic  store;
    step_e step;
  } wheel_upd_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [31:0] mean_distance;
  } result_t;

endpackage

// File: rtl/dqd_wheel.sv
// Quadrature transition decoder for one wheel.
module dqd_wheel (
  input  dqd_pkg::mode_e      mode_i,
  input  logic [1:0]          prev_i,
  input  logic [1:0]          cur_i,
  output dqd_pkg::wheel_upd_t upd_o
);

  logic [1:0] diff;

  assign diff = prev_i ^ cur_i;

  // Classify the transition from the stored state to the new sample.
  always_comb begin
    upd_o.store = 1'b0;
    upd_o.step  = dqd_pkg::STEP_HOLD;
    case (mode_i)
      dqd_pkg::MODE_X2: begin
        // Act only on an edge of channel A.
        if (diff[1]) begin
          upd_o.store = 1'b1;
          if (diff[0]) begin
            // 11<->00 counts up, 10<->01 counts down.
            upd_o.step = (prev_i[1] == prev_i[0]) ? dqd_pkg::STEP_INC : dqd_pkg::STEP_DEC;
          end
        end
      end
      dqd_pkg::MODE_X4: begin
        upd_o.store = 1'b1;
        // A single-bit change counts; a double change is skipped.
        if (diff[1] ^ diff[0]) begin
          upd_o.step = (prev_i[0] ^ cur_i[1]) ? dqd_pkg::STEP_DEC : dqd_pkg::STEP_INC;
        end
      end
      default: begin
        upd_o.store = 1'b0;
        upd_o.step  = dqd_pkg::STEP_HOLD;
      end
    endcase
  end

endmodule

// File: rtl/dual_quadrature_decoder_unit.sv
// Top level of the dual quadrature decoder: counters, config port and output buffer.
//
// Usage: each input transfer carries either a sample of both wheels' A and B
// lines (operation 0) or a clear of both counts (operation 1). Every input
// transfer yields exactly one result transfer with both counts and their
// mean, truncated toward zero. The counts update at the edge that accepts
// the input, and the result is registered into the output or skid register.
// Throughput is one item per cycle while in_ready_o is high; the only loop is the count increment.
// A two-entry output buffer (output register plus skid register) keeps
// in_ready_o high while one result waits; in_ready_o drops only when both
// entries hold results the receiver has not taken.
// The counting mode is set through the APB port (register 0, bit 0:
// 0 = X2, 1 = X4); write it only while the block is idle.
// Reset clears counts, stored line states, the mode and the buffer. The
// first sample after reset only records the line states.
`include "dual_quadrature_decoder_unit_defines.svh"

module dual_quadrature_decoder_unit #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // APB configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               operation_i,
  input  logic               left_chan_a_i,
  input  logic               left_chan_b_i,
  input  logic               right_chan_a_i,
  input  logic               right_chan_b_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] left_count_o,
  output logic signed [31:0] right_count_o,
  output logic signed [31:0] mean_distance_o
);

  localparam int unsigned OutW  = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
  localparam int unsigned MeanW = (COUNT_WIDTH + 1 > 32) ? COUNT_WIDTH + 1 : 32;

  dqd_pkg::mode_e mode_q;
  logic           primed_q, primed_d;
  logic [1:0]     left_last_q, left_last_d;
  logic [1:0]     right_last_q, right_last_d;
  logic signed [COUNT_WIDTH-1:0] left_q, left_d;
  logic signed [COUNT_WIDTH-1:0] right_q, right_d;

  logic [1:0] left_cur, right_cur;
  dqd_pkg::wheel_upd_t left_upd, right_upd;

  logic accept, take, cfg_write;
  logic signed [COUNT_WIDTH:0] sum;
  logic signed [COUNT_WIDTH:0] half;
  logic signed [OutW-1:0]  left_ext, right_ext;
  logic signed [MeanW-1:0] mean_ext;
  dqd_pkg::result_t result;

  logic             out_valid_q, skid_valid_q;
  dqd_pkg::result_t out_data_q, skid_data_q;

  // Configuration port: always ready, one register.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr[2] == dqd_pkg::REG_ENCODING_MODE) begin
      prdata[0] = mode_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= dqd_pkg::MODE_X2;
    end else if (cfg_write && paddr[2] == dqd_pkg::REG_ENCODING_MODE) begin
      mode_q <= dqd_pkg::mode_e'(pwdata[0]);
    end
  end

  // Handshakes.
  assign in_ready_o = !skid_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign take       = out_valid_q && out_ready_i;

  // Per-wheel transition decode.
  assign left_cur  = {left_chan_a_i, left_chan_b_i};
  assign right_cur = {right_chan_a_i, right_chan_b_i};

  dqd_wheel u_left (
    .mode_i (mode_q),
    .prev_i (left_last_q),
    .cur_i  (left_cur),
    .upd_o  (left_upd)
  );

  dqd_wheel u_right (
    .mode_i (mode_q),
    .prev_i (right_last_q),
    .cur_i  (right_cur),
    .upd_o  (right_upd)
  );

  // Next counts and stored states.
  always_comb begin
    primed_d     = primed_q;
    left_last_d  = left_last_q;
    right_last_d = right_last_q;
    left_d       = left_q;
    right_d      = right_q;
    if (accept) begin
      if (operation_i == dqd_pkg::OP_CLEAR) begin
        left_d  = '0;
        right_d = '0;
      end else if (!primed_q) begin
        primed_d     = 1'b1;
        left_last_d  = left_cur;
        right_last_d = right_cur;
      end else begin
        if (left_upd.store) begin
          left_last_d = left_cur;
        end
        if (right_upd.store) begin
          right_last_d = right_cur;
        end
        case (left_upd.step)
          dqd_pkg::STEP_INC: left_d = left_q + COUNT_WIDTH'(1);
          dqd_pkg::STEP_DEC: left_d = left_q - COUNT_WIDTH'(1);
          default:           left_d = left_q;
        endcase
        case (right_upd.step)
          dqd_pkg::STEP_INC: right_d = right_q + COUNT_WIDTH'(1);
          dqd_pkg::STEP_DEC: right_d = right_q - COUNT_WIDTH'(1);
          default:           right_d = right_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q     <= 1'b0;
      left_last_q  <= 2'b00;
      right_last_q <= 2'b00;
      left_q       <= '0;
      right_q      <= '0;
    end else begin
      primed_q     <= primed_d;
      left_last_q  <= left_last_d;
      right_last_q <= right_last_d;
      left_q       <= left_d;
      right_q      <= right_d;
    end
  end

  // Mean of both counts, rounded toward zero.
  always_comb begin
    sum  = (COUNT_WIDTH + 1)'(left_d) + (COUNT_WIDTH + 1)'(right_d);
    half = sum >>> 1;
    if (sum[COUNT_WIDTH] && sum[0]) begin
      half = half + (COUNT_WIDTH + 1)'(1);
    end
    left_ext  = OutW'(left_d);
    right_ext = OutW'(right_d);
    mean_ext  = MeanW'(half);
    result.left_count    = left_ext[31:0];
    result.right_count   = right_ext[31:0];
    result.mean_distance = mean_ext[31:0];
  end

  // Output register with a skid entry behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end
    end else if (accept) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_data_q <= skid_data_q;
      end
    end else if (accept) begin
      if (!out_valid_q || take) begin
        out_data_q <= result;
      end else begin
        skid_data_q <= result;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign left_count_o    = out_data_q.left_count;
  assign right_count_o   = out_data_q.right_count;
  assign mean_distance_o = out_data_q.mean_distance;

  // Assertions.
  `DQD_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_q |-> out_valid_q, "skid entry without output entry")
  `DQD_ASSERT(a_clear_zeroes, accept && operation_i == dqd_pkg::OP_CLEAR |=> left_q == '0 && right_q == '0, "clear did not zero the counts")
  `DQD_ASSERT(a_first_sample_records, accept && !primed_q && operation_i == dqd_pkg::OP_SAMPLE |=> $stable(left_q) && $stable(right_q) && primed_q, "first sample changed a count")

endmodule
